// ===== rtl/pcd_pkg.sv =====
// pcd_pkg: codes and constants shared by the PNG chunk deframer and its checker.
// No dependencies.
package pcd_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;

  localparam phase_t PH_SIG  = 3'd0;
  localparam phase_t PH_LEN  = 3'd1;
  localparam phase_t PH_TYPE = 3'd2;
  localparam phase_t PH_DATA = 3'd3;
  localparam phase_t PH_CRC  = 3'd4;

  localparam kind_t KIND_SIG  = 3'd0;
  localparam kind_t KIND_LEN  = 3'd1;
  localparam kind_t KIND_TYPE = 3'd2;
  localparam kind_t KIND_DATA = 3'd3;
  localparam kind_t KIND_CRC  = 3'd4;
  localparam kind_t KIND_NONE = 3'd5;

  localparam status_t ST_BUSY      = 3'd0;
  localparam status_t ST_DONE      = 3'd1;
  localparam status_t ST_BAD_SIG   = 3'd2;
  localparam status_t ST_CHUNK_BIG = 3'd3;
  localparam status_t ST_FILE_BIG  = 3'd4;
  localparam status_t ST_TRUNC     = 3'd5;

  // element 0 is the first signature byte
  localparam logic [0:7][7:0] PNG_SIG = {8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [31:0] IEND_WORD = 32'h49454E44;

  localparam logic [30:0] MAX_CHUNK_RST = 31'(4096 * 10 * 2);
  localparam logic [31:0] MAX_FILE_RST  = 32'(4096 * 1024 * 10);

endpackage

// ===== rtl/png_chunk_deframer.sv =====
// png_chunk_deframer: PNG signature check and chunk framing, one byte per transaction.
// Depends on pcd_pkg.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_func, in_data_byte
//  out_    | output    | out_valid/out_ready  | out_out_byte, out_byte_kind, out_status,
//          |           |                      | out_file_length
//  cfg     | APB       | psel/penable/pready  | paddr, pwdata, prdata
//
// One input transaction per cycle while in_ready is high; its result appears in the output register the next cycle.
// All parsing is compares and counter updates on the accepted byte and the parser state.
// in_ready drops only while the output register holds a result that is not taken.
// rst_n is synchronous; it returns the parser to the signature phase and loads the
// default limits.
module png_chunk_deframer #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic [2:0]  out_byte_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_file_length,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // configuration
  logic [30:0] max_chunk_r;
  logic [31:0] max_file_r;

  // parser state
  pcd_pkg::phase_t         phase_r, phase_nxt;
  logic [2:0]              fpos_r, fpos_nxt;
  logic                    mism_r, mism_nxt;
  logic [31:0]             clen_r, clen_nxt;
  logic [31:0]             drem_r, drem_nxt;
  logic [31:0]             ctype_r, ctype_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  // output register
  logic                    out_valid_r;
  logic [7:0]              obyte_r, obyte_nxt;
  pcd_pkg::kind_t          okind_r, okind_nxt;
  pcd_pkg::status_t        ostat_r, ostat_nxt;
  logic [31:0]             olen_r, olen_nxt;

  logic                    accept;
  logic                    cfg_wr;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic [CMP_W-1:0]        cnt_wide;
  logic [31:0]             cnt_shown;
  logic                    file_full;
  logic                    restart;
  logic                    mism_now;
  logic [31:0]             clen_shift;
  logic [31:0]             drem_dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = paddr[2] ? max_file_r : {1'b0, max_chunk_r};

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign out_valid       = out_valid_r;
  assign out_out_byte    = obyte_r;
  assign out_byte_kind   = okind_r;
  assign out_status      = ostat_r;
  assign out_file_length = olen_r;

  // byte count with this byte included, saturating
  assign cnt_inc   = (cnt_r != {COUNT_WIDTH{1'b1}}) ? cnt_r + 1'b1 : cnt_r;
  assign cnt_wide  = CMP_W'(cnt_inc);
  assign cnt_shown = (cnt_wide > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_wide[31:0];
  assign file_full = cnt_wide >= CMP_W'(max_file_r);

  assign mism_now   = mism_r || (in_data_byte != pcd_pkg::PNG_SIG[fpos_r]);
  assign clen_shift = {clen_r[23:0], in_data_byte};
  assign drem_dec   = (drem_r != '0) ? drem_r - 1'b1 : drem_r;

  always_comb begin
    phase_nxt = phase_r;
    fpos_nxt  = fpos_r;
    mism_nxt  = mism_r;
    clen_nxt  = clen_r;
    drem_nxt  = drem_r;
    ctype_nxt = ctype_r;
    cnt_nxt   = cnt_r;
    restart   = 1'b0;
    obyte_nxt = in_data_byte;
    okind_nxt = pcd_pkg::KIND_NONE;
    ostat_nxt = pcd_pkg::ST_BUSY;
    olen_nxt  = cnt_shown;

    if (in_func) begin
      obyte_nxt = 8'd0;
      if (phase_r == pcd_pkg::PH_SIG && fpos_r == 3'd0) begin
        olen_nxt = 32'd0;
      end else begin
        olen_nxt  = (CMP_W'(cnt_r) > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                             : 32'(cnt_r);
        ostat_nxt = pcd_pkg::ST_TRUNC;
        restart   = 1'b1;
      end
    end else begin
      cnt_nxt = cnt_inc;
      unique case (phase_r)
        pcd_pkg::PH_SIG: begin
          okind_nxt = pcd_pkg::KIND_SIG;
          mism_nxt  = mism_now;
          if (fpos_r == 3'd7) begin
            if (mism_now) begin
              restart   = 1'b1;
              ostat_nxt = pcd_pkg::ST_BAD_SIG;
            end else if (file_full) begin
              restart   = 1'b1;
              ostat_nxt = pcd_pkg::ST_FILE_BIG;
            end else begin
              phase_nxt = pcd_pkg::PH_LEN;
              fpos_nxt  = 3'd0;
              clen_nxt  = 32'd0;
            end
          end else begin
            fpos_nxt = fpos_r + 3'd1;
          end
        end
        pcd_pkg::PH_LEN: begin
          okind_nxt = pcd_pkg::KIND_LEN;
          clen_nxt  = clen_shift;
          if (fpos_r >= 3'd3) begin
            if (clen_shift >= {1'b0, max_chunk_r}) begin
              restart   = 1'b1;
              ostat_nxt = pcd_pkg::ST_CHUNK_BIG;
            end else begin
              phase_nxt = pcd_pkg::PH_TYPE;
              fpos_nxt  = 3'd0;
              ctype_nxt = 32'd0;
            end
          end else begin
            fpos_nxt = fpos_r + 3'd1;
          end
        end
        pcd_pkg::PH_TYPE: begin
          okind_nxt = pcd_pkg::KIND_TYPE;
          ctype_nxt = {ctype_r[23:0], in_data_byte};
          if (fpos_r >= 3'd3) begin
            fpos_nxt  = 3'd0;
            drem_nxt  = clen_r;
            phase_nxt = (clen_r == 32'd0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
          end else begin
            fpos_nxt = fpos_r + 3'd1;
          end
        end
        pcd_pkg::PH_DATA: begin
          okind_nxt = pcd_pkg::KIND_DATA;
          drem_nxt  = drem_dec;
          if (drem_dec == 32'd0) begin
            phase_nxt = pcd_pkg::PH_CRC;
            fpos_nxt  = 3'd0;
          end
        end
        default: begin
          // CRC bytes pass unchecked
          okind_nxt = pcd_pkg::KIND_CRC;
          if (fpos_r >= 3'd3) begin
            if (ctype_r == pcd_pkg::IEND_WORD) begin
              restart   = 1'b1;
              ostat_nxt = pcd_pkg::ST_DONE;
            end else if (file_full) begin
              restart   = 1'b1;
              ostat_nxt = pcd_pkg::ST_FILE_BIG;
            end else begin
              phase_nxt = pcd_pkg::PH_LEN;
              fpos_nxt  = 3'd0;
              clen_nxt  = 32'd0;
            end
          end else begin
            fpos_nxt = fpos_r + 3'd1;
          end
        end
      endcase
    end

    if (restart) begin
      phase_nxt = pcd_pkg::PH_SIG;
      fpos_nxt  = 3'd0;
      mism_nxt  = 1'b0;
      clen_nxt  = 32'd0;
      drem_nxt  = 32'd0;
      ctype_nxt = 32'd0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chunk_r <= pcd_pkg::MAX_CHUNK_RST;
      max_file_r  <= pcd_pkg::MAX_FILE_RST;
      phase_r     <= pcd_pkg::PH_SIG;
      fpos_r      <= 3'd0;
      mism_r      <= 1'b0;
      clen_r      <= 32'd0;
      drem_r      <= 32'd0;
      ctype_r     <= 32'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          max_file_r <= pwdata;
        end else begin
          max_chunk_r <= pwdata[30:0];
        end
      end
      if (accept) begin
        phase_r <= phase_nxt;
        fpos_r  <= fpos_nxt;
        mism_r  <= mism_nxt;
        clen_r  <= clen_nxt;
        drem_r  <= drem_nxt;
        ctype_r <= ctype_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      obyte_r <= obyte_nxt;
      okind_r <= okind_nxt;
      ostat_r <= ostat_nxt;
      olen_r  <= olen_nxt;
    end
  end

endmodule

// ===== rtl/pcd_checker.sv =====
// pcd_checker: port-level assertions for png_chunk_deframer, bound to the top level.
// Depends on pcd_pkg and png_chunk_deframer.
module pcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_out_byte,
  input logic [2:0]  out_byte_kind,
  input logic [2:0]  out_status,
  input logic [31:0] out_file_length
);

  // a result not taken stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_file_length))
    else $error("result dropped or changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_eod_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_kind == pcd_pkg::KIND_NONE |-> out_out_byte == 8'd0)
    else $error("end-of-data transaction echoes a nonzero byte");

  a_bad_sig: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pcd_pkg::ST_BAD_SIG |->
      out_byte_kind == pcd_pkg::KIND_SIG && out_file_length == 32'd8)
    else $error("bad signature reported off the eighth signature byte");

  a_done_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pcd_pkg::ST_DONE |-> out_byte_kind == pcd_pkg::KIND_CRC)
    else $error("completion reported off a CRC byte");

endmodule

bind png_chunk_deframer pcd_checker u_pcd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_out_byte    (out_out_byte),
  .out_byte_kind   (out_byte_kind),
  .out_status      (out_status),
  .out_file_length (out_file_length)
);

// ===== bench/png_chunk_deframer_tb.sv =====
// png_chunk_deframer_tb: self-checking bench for the PNG chunk deframer, with a
// behavioral parser that predicts every result transaction. Depends on pcd_pkg and
// png_chunk_deframer.
module png_chunk_deframer_tb;

  localparam int CNT_W = 32;
  localparam int REG_MAX_CHUNK = 0;
  localparam int REG_MAX_FILE  = 1;

  typedef struct packed {
    logic [7:0]       echo;
    pcd_pkg::kind_t   kind;
    pcd_pkg::status_t status;
    logic [31:0]      flen;
  } frame_res_t;

  typedef struct {
    bit          is_end;
    logic [7:0]  b;
    bit          typed;
    frame_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic [2:0]  out_byte_kind;
  logic [2:0]  out_status;
  logic [31:0] out_file_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  png_chunk_deframer #(.COUNT_WIDTH(CNT_W)) u_top (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_data_byte,
    .out_valid, .out_ready, .out_out_byte, .out_byte_kind, .out_status, .out_file_length,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // parser state and limits as the bench believes them to be
  logic [30:0]      lim_chunk;
  logic [31:0]      lim_file;
  pcd_pkg::phase_t  pr_phase;
  logic [2:0]       pr_pos;
  bit               pr_sig_bad;
  logic [31:0]      pr_len;
  logic [31:0]      pr_left;
  logic [31:0]      pr_type;
  logic [CNT_W-1:0] pr_count;

  stim_row_t  stim_q[$];
  frame_res_t pending_res[$];
  frame_res_t mon_want;
  int         mismatches = 0;

  function automatic void restart_parse();
    pr_phase   = pcd_pkg::PH_SIG;
    pr_pos     = '0;
    pr_sig_bad = 1'b0;
    pr_len     = '0;
    pr_left    = '0;
    pr_type    = '0;
    pr_count   = '0;
  endfunction

  function automatic pcd_pkg::status_t open_chunk();
    if (pr_count >= lim_file) begin
      restart_parse();
      return pcd_pkg::ST_FILE_BIG;
    end
    pr_phase = pcd_pkg::PH_LEN;
    pr_pos   = '0;
    pr_len   = '0;
    return pcd_pkg::ST_BUSY;
  endfunction

  function automatic frame_res_t parse_item(bit is_end, logic [7:0] b);
    frame_res_t r;
    r.echo   = is_end ? 8'h00 : b;
    r.status = pcd_pkg::ST_BUSY;
    if (is_end) begin
      r.kind = pcd_pkg::KIND_NONE;
      r.flen = pr_count;
      if (pr_phase == pcd_pkg::PH_SIG && pr_pos == 0) begin
        r.flen = '0;
      end else begin
        r.status = pcd_pkg::ST_TRUNC;
        restart_parse();
      end
      return r;
    end
    if (pr_count != '1) pr_count++;
    r.flen = pr_count;
    case (pr_phase)
      pcd_pkg::PH_SIG: begin
        r.kind = pcd_pkg::KIND_SIG;
        if (b != pcd_pkg::PNG_SIG[pr_pos]) pr_sig_bad = 1'b1;
        if (pr_pos == 3'd7) begin
          if (pr_sig_bad) begin
            restart_parse();
            r.status = pcd_pkg::ST_BAD_SIG;
          end else begin
            r.status = open_chunk();
          end
        end else begin
          pr_pos++;
        end
      end
      pcd_pkg::PH_LEN: begin
        r.kind = pcd_pkg::KIND_LEN;
        pr_len = {pr_len[23:0], b};
        if (pr_pos == 3'd3) begin
          if (pr_len >= {1'b0, lim_chunk}) begin
            restart_parse();
            r.status = pcd_pkg::ST_CHUNK_BIG;
          end else begin
            pr_phase = pcd_pkg::PH_TYPE;
            pr_pos   = '0;
            pr_type  = '0;
          end
        end else begin
          pr_pos++;
        end
      end
      pcd_pkg::PH_TYPE: begin
        r.kind = pcd_pkg::KIND_TYPE;
        pr_type = {pr_type[23:0], b};
        if (pr_pos == 3'd3) begin
          pr_pos   = '0;
          pr_left  = pr_len;
          pr_phase = (pr_len == 0) ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
        end else begin
          pr_pos++;
        end
      end
      pcd_pkg::PH_DATA: begin
        r.kind = pcd_pkg::KIND_DATA;
        if (pr_left != 0) pr_left--;
        if (pr_left == 0) begin
          pr_phase = pcd_pkg::PH_CRC;
          pr_pos   = '0;
        end
      end
      default: begin
        r.kind = pcd_pkg::KIND_CRC;
        if (pr_pos == 3'd3) begin
          if (pr_type == pcd_pkg::IEND_WORD) begin
            restart_parse();
            r.status = pcd_pkg::ST_DONE;
          end else begin
            r.status = open_chunk();
          end
        end else begin
          pr_pos++;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(bit e, logic [7:0] b, bit typed = 1'b0,
                                  pcd_pkg::kind_t k = pcd_pkg::KIND_NONE,
                                  pcd_pkg::status_t s = pcd_pkg::ST_BUSY,
                                  logic [31:0] fl = 32'd0);
    stim_row_t row;
    row.is_end = e;
    row.b      = b;
    row.typed  = typed;
    row.res    = '{echo: (e ? 8'h00 : b), kind: k, status: s, flen: fl};
    stim_q.push_back(row);
  endfunction

  // One file's worth of stimulus: mostly well-formed, sometimes corrupted or cut short.
  task automatic queue_random_file();
    logic [7:0]  body[$];
    logic [31:0] ln;
    logic [31:0] ty;
    int          n_chunks;
    int          nd;
    int          cut;
    int          r;
    bit          cut_short;
    cut_short = 1'b0;
    if ($urandom_range(0, 9) == 0) add_row(1'b1, 8'($urandom));
    for (int i = 0; i < 8; i++) body.push_back(pcd_pkg::PNG_SIG[i]);
    if ($urandom_range(0, 9) == 0) body[$urandom_range(0, 7)] = 8'($urandom);
    n_chunks = $urandom_range(0, 3);
    for (int c = 0; c <= n_chunks && !cut_short; c++) begin
      r = $urandom_range(0, 19);
      if (r == 0) ln = $urandom;
      else if (r < 3) ln = {1'b0, lim_chunk} + $urandom_range(0, 2) - 1;
      else ln = $urandom_range(0, 12);
      ty = (c == n_chunks && $urandom_range(0, 7) != 0) ? pcd_pkg::IEND_WORD : $urandom;
      for (int i = 3; i >= 0; i--) body.push_back(ln[8*i +: 8]);
      for (int i = 3; i >= 0; i--) body.push_back(ty[8*i +: 8]);
      nd = (ln > 64) ? 64 : int'(ln);
      for (int i = 0; i < nd; i++) body.push_back(8'($urandom));
      // long chunks are never completed: the data is cut short by end of data
      if (ln > 64) cut_short = 1'b1;
      else for (int i = 0; i < 4; i++) body.push_back(8'($urandom));
    end
    if (!cut_short && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
      cut_short = 1'b1;
    end
    foreach (body[i]) add_row(1'b0, body[i]);
    if (cut_short) add_row(1'b1, 8'($urandom));
    else if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 4)) add_row(1'b0, 8'($urandom));
  endtask

  task automatic drive_queued();
    stim_row_t  row;
    frame_res_t pred;
    int         gap;
    bit         burst;
    burst = 1'b0;
    while (stim_q.size() != 0) begin
      row = stim_q.pop_front();
      if ($urandom_range(0, 31) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid     <= 1'b1;
      in_func      <= row.is_end;
      in_data_byte <= row.b;
      do @(posedge clk); while (!in_ready);
      pred = parse_item(row.is_end, row.b);
      pending_res.push_back(row.typed ? row.res : pred);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_access(int idx, logic [31:0] val, logic [31:0] back);
    paddr   <= 3'(4 * idx);
    pwdata  <= val;
    pwrite  <= 1'b1;
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== back) begin
      $error("prdata[%0d]: expected %h, got %h", idx, back, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] chunk_v, logic [31:0] file_v, int n_items);
    lim_chunk = chunk_v[30:0];
    lim_file  = file_v;
    reg_access(REG_MAX_CHUNK, chunk_v, {1'b0, chunk_v[30:0]});
    reg_access(REG_MAX_FILE, file_v, file_v);
    while (stim_q.size() < n_items) queue_random_file();
    drive_queued();
    drain();
  endtask

  // result side: random stalls between transactions, with stall-free stretches
  initial begin
    int stall;
    bit burst;
    burst = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $error("result transaction with nothing pending");
        mismatches++;
      end else begin
        mon_want = pending_res.pop_front();
        if (out_out_byte !== mon_want.echo) begin
          $error("out_byte: expected %h, got %h", mon_want.echo, out_out_byte);
          mismatches++;
        end
        if (out_byte_kind !== mon_want.kind) begin
          $error("byte_kind: expected %0d, got %0d", mon_want.kind, out_byte_kind);
          mismatches++;
        end
        if (out_status !== mon_want.status) begin
          $error("status: expected %0d, got %0d", mon_want.status, out_status);
          mismatches++;
        end
        if (out_file_length !== mon_want.flen) begin
          $error("file_length: expected %0d, got %0d", mon_want.flen, out_file_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    lim_chunk = pcd_pkg::MAX_CHUNK_RST;
    lim_file  = pcd_pkg::MAX_FILE_RST;
    restart_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle end of data, a minimal PNG, then a cut-off signature
    //       end   byte   typed kind                status               file_length
    add_row(1'b1, 8'hFF, 1'b1, pcd_pkg::KIND_NONE, pcd_pkg::ST_BUSY,  32'd0);
    add_row(1'b0, 8'h89, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd1);
    add_row(1'b0, 8'h50, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd2);
    add_row(1'b0, 8'h4E, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd3);
    add_row(1'b0, 8'h47, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd4);
    add_row(1'b0, 8'h0D, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd5);
    add_row(1'b0, 8'h0A, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd6);
    add_row(1'b0, 8'h1A, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd7);
    add_row(1'b0, 8'h0A, 1'b1, pcd_pkg::KIND_SIG,  pcd_pkg::ST_BUSY,  32'd8);
    add_row(1'b0, 8'h00);
    add_row(1'b0, 8'h00);
    add_row(1'b0, 8'h00);
    add_row(1'b0, 8'h00);
    add_row(1'b0, 8'h49);
    add_row(1'b0, 8'h45);
    add_row(1'b0, 8'h4E);
    add_row(1'b0, 8'h44);
    add_row(1'b0, 8'hAE);
    add_row(1'b0, 8'h42);
    add_row(1'b0, 8'h60);
    add_row(1'b0, 8'h82, 1'b1, pcd_pkg::KIND_CRC,  pcd_pkg::ST_DONE,  32'd20);
    add_row(1'b0, 8'hFF);
    add_row(1'b1, 8'h00, 1'b1, pcd_pkg::KIND_NONE, pcd_pkg::ST_TRUNC, 32'd1);
    drive_queued();
    drain();

    // random phases under reset limits, then the extremes, then mixed settings
    while (stim_q.size() < 300) queue_random_file();
    drive_queued();
    drain();
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 100);
    run_phase(32'h7FFF_FFFF, 32'h0000_0000, 100);
    run_phase(32'd16, 32'd64, 250);
    run_phase($urandom_range(1, 40), $urandom_range(8, 200), 300);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pcd_pkg.sv
rtl/png_chunk_deframer.sv
rtl/pcd_checker.sv
bench/png_chunk_deframer_tb.sv
